@@ hdl/hkm_pkg.sv @@
// shared types, constants and lookup tables of the host key to matrix mapper
package hkm_pkg;

    localparam int MATRIX_ROWS = 10;
    localparam int ROW_W       = $clog2(MATRIX_ROWS);
    localparam int SEL_W       = 4;
    localparam int ROW_BITS    = 8;

    localparam logic [ROW_W-1:0]    SHIFT_ROW = ROW_W'(2);
    localparam logic [ROW_BITS-1:0] SHIFT_CLR = 8'd223;
    localparam logic [ROW_BITS-1:0] SHIFT_SET = 8'd32;
    localparam logic [ROW_BITS-1:0] ROW_IDLE  = 8'd255;

    // action codes
    localparam logic [1:0] ACT_PRESS   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    // shift bit operations
    localparam logic [1:0] SHIFT_OP_NONE = 2'd0;
    localparam logic [1:0] SHIFT_OP_CLR  = 2'd1;
    localparam logic [1:0] SHIFT_OP_SET  = 2'd2;

    // host command codes
    localparam logic [3:0] CMD_NONE       = 4'd0;
    localparam logic [3:0] CMD_INFO       = 4'd1;
    localparam logic [3:0] CMD_DISK0      = 4'd2;
    localparam logic [3:0] CMD_DISK1      = 4'd3;
    localparam logic [3:0] CMD_SOUND      = 4'd4;
    localparam logic [3:0] CMD_SCREENSHOT = 4'd5;
    localparam logic [3:0] CMD_SETUP      = 4'd6;
    localparam logic [3:0] CMD_RESET      = 4'd7;
    localparam logic [3:0] CMD_PRN_CLOSE  = 4'd8;
    localparam logic [3:0] CMD_DEBUG      = 4'd9;
    localparam logic [3:0] CMD_EXIT       = 4'd10;

    // host key symbols
    localparam logic [15:0] KEY_PRINT_LO = 16'd32;
    localparam logic [15:0] KEY_PRINT_HI = 16'd125;
    localparam logic [15:0] KEY_SHIFT_L  = 16'hffe1;
    localparam logic [15:0] KEY_SHIFT_R  = 16'hffe2;
    localparam logic [15:0] KEY_CTRL_L   = 16'hffe3;
    localparam logic [15:0] KEY_CTRL_R   = 16'hffe4;
    localparam logic [15:0] KEY_F1       = 16'hffbe;
    localparam logic [15:0] KEY_F12      = 16'hffc9;

    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [ROW_BITS-1:0] mask;
        logic                shift;
    } ascii_entry_t;

    typedef struct packed {
        logic                hit;
        logic [ROW_W-1:0]    row;
        logic [ROW_BITS-1:0] mask;
    } special_entry_t;

    // matrix change requested by one item
    typedef struct packed {
        logic                tgt_en;
        logic [ROW_W-1:0]    tgt_row;
        logic [ROW_BITS-1:0] tgt_and;
        logic [ROW_BITS-1:0] tgt_or;
        logic [1:0]          shift_op;
        logic                hsf_set;
        logic                hsf_clr;
        logic                ctrl_set;
        logic                ctrl_clr;
        logic [3:0]          cmd;
    } hkm_update_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] row_value;
        logic [3:0]          host_command;
        logic                ctrl_held;
        logic                shift_held;
    } hkm_result_t;

    // row, press mask and implied shift for codes 32 to 125
    localparam ascii_entry_t ASCII_ROM [94] = '{
        '{4'd5, 8'd127, 1'b0}, '{4'd8, 8'd254, 1'b1}, '{4'd8, 8'd253, 1'b1}, '{4'd7, 8'd253, 1'b1},
        '{4'd7, 8'd254, 1'b1}, '{4'd6, 8'd253, 1'b1}, '{4'd6, 8'd254, 1'b1}, '{4'd5, 8'd253, 1'b1},
        '{4'd5, 8'd254, 1'b1}, '{4'd4, 8'd253, 1'b1}, '{4'd3, 8'd223, 1'b1}, '{4'd3, 8'd239, 1'b1},
        '{4'd4, 8'd127, 1'b0}, '{4'd3, 8'd253, 1'b0}, '{4'd3, 8'd127, 1'b0}, '{4'd3, 8'd191, 1'b0},
        '{4'd4, 8'd254, 1'b0}, '{4'd8, 8'd254, 1'b0}, '{4'd8, 8'd253, 1'b0}, '{4'd7, 8'd253, 1'b0},
        '{4'd7, 8'd254, 1'b0}, '{4'd6, 8'd253, 1'b0}, '{4'd6, 8'd254, 1'b0}, '{4'd5, 8'd253, 1'b0},
        '{4'd5, 8'd254, 1'b0}, '{4'd4, 8'd253, 1'b0}, '{4'd3, 8'd223, 1'b0}, '{4'd3, 8'd239, 1'b0},
        '{4'd4, 8'd127, 1'b1}, '{4'd3, 8'd253, 1'b1}, '{4'd3, 8'd127, 1'b1}, '{4'd3, 8'd191, 1'b1},
        '{4'd3, 8'd251, 1'b0},
        '{4'd8, 8'd223, 1'b1}, '{4'd6, 8'd191, 1'b1}, '{4'd7, 8'd191, 1'b1}, '{4'd7, 8'd223, 1'b1},
        '{4'd7, 8'd251, 1'b1}, '{4'd6, 8'd223, 1'b1}, '{4'd6, 8'd239, 1'b1}, '{4'd5, 8'd239, 1'b1},
        '{4'd4, 8'd247, 1'b1}, '{4'd5, 8'd223, 1'b1}, '{4'd4, 8'd223, 1'b1}, '{4'd4, 8'd239, 1'b1},
        '{4'd4, 8'd191, 1'b1}, '{4'd5, 8'd191, 1'b1}, '{4'd4, 8'd251, 1'b1}, '{4'd3, 8'd247, 1'b1},
        '{4'd8, 8'd247, 1'b1}, '{4'd6, 8'd251, 1'b1}, '{4'd7, 8'd239, 1'b1}, '{4'd6, 8'd247, 1'b1},
        '{4'd5, 8'd251, 1'b1}, '{4'd6, 8'd127, 1'b1}, '{4'd7, 8'd247, 1'b1}, '{4'd7, 8'd127, 1'b1},
        '{4'd5, 8'd247, 1'b1}, '{4'd8, 8'd127, 1'b1},
        '{4'd2, 8'd253, 1'b0}, '{4'd2, 8'd191, 1'b0}, '{4'd2, 8'd247, 1'b0}, '{4'd3, 8'd254, 1'b0},
        '{4'd4, 8'd254, 1'b1}, '{4'd2, 8'd191, 1'b1},
        '{4'd8, 8'd223, 1'b0}, '{4'd6, 8'd191, 1'b0}, '{4'd7, 8'd191, 1'b0}, '{4'd7, 8'd223, 1'b0},
        '{4'd7, 8'd251, 1'b0}, '{4'd6, 8'd223, 1'b0}, '{4'd6, 8'd239, 1'b0}, '{4'd5, 8'd239, 1'b0},
        '{4'd4, 8'd247, 1'b0}, '{4'd5, 8'd223, 1'b0}, '{4'd4, 8'd223, 1'b0}, '{4'd4, 8'd239, 1'b0},
        '{4'd4, 8'd191, 1'b0}, '{4'd5, 8'd191, 1'b0}, '{4'd4, 8'd251, 1'b0}, '{4'd3, 8'd247, 1'b0},
        '{4'd8, 8'd247, 1'b0}, '{4'd6, 8'd251, 1'b0}, '{4'd7, 8'd239, 1'b0}, '{4'd6, 8'd247, 1'b0},
        '{4'd5, 8'd251, 1'b0}, '{4'd6, 8'd127, 1'b0}, '{4'd7, 8'd247, 1'b0}, '{4'd7, 8'd127, 1'b0},
        '{4'd5, 8'd247, 1'b0}, '{4'd8, 8'd127, 1'b0},
        '{4'd2, 8'd253, 1'b1}, '{4'd3, 8'd251, 1'b1}, '{4'd2, 8'd247, 1'b1}
    };

    // special key symbols with a matrix position
    function automatic special_entry_t special_lookup(input logic [15:0] code);
        special_entry_t e;
        e = '{1'b1, ROW_W'(0), 8'd255};
        case (code)
            16'hff08: e = '{1'b1, 4'd9, 8'd127};
            16'hff0d: e = '{1'b1, 4'd2, 8'd251};
            16'hffe3: e = '{1'b1, 4'd2, 8'd127};
            16'hffe4: e = '{1'b1, 4'd2, 8'd127};
            16'hffe7: e = '{1'b1, 4'd1, 8'd253};
            16'hffe9: e = '{1'b1, 4'd1, 8'd253};
            16'hffff: e = '{1'b1, 4'd2, 8'd254};
            16'hff09: e = '{1'b1, 4'd8, 8'd239};
            16'hff51: e = '{1'b1, 4'd1, 8'd254};
            16'hff52: e = '{1'b1, 4'd0, 8'd254};
            16'hff53: e = '{1'b1, 4'd0, 8'd253};
            16'hff54: e = '{1'b1, 4'd0, 8'd251};
            16'hffb1: e = '{1'b1, 4'd1, 8'd223};
            16'hffb2: e = '{1'b1, 4'd1, 8'd191};
            16'hffb3: e = '{1'b1, 4'd0, 8'd223};
            16'hffb4: e = '{1'b1, 4'd2, 8'd239};
            16'hffb5: e = '{1'b1, 4'd1, 8'd239};
            16'hffb6: e = '{1'b1, 4'd0, 8'd239};
            16'hffb7: e = '{1'b1, 4'd1, 8'd251};
            16'hffb8: e = '{1'b1, 4'd1, 8'd247};
            16'hffb9: e = '{1'b1, 4'd0, 8'd247};
            16'hffb0: e = '{1'b1, 4'd1, 8'd127};
            16'hff8d: e = '{1'b1, 4'd0, 8'd191};
            16'hffae: e = '{1'b1, 4'd0, 8'd127};
            16'hff98: e = '{1'b1, 4'd9, 8'd247};
            16'hff96: e = '{1'b1, 4'd9, 8'd251};
            16'hff97: e = '{1'b1, 4'd9, 8'd254};
            16'hff99: e = '{1'b1, 4'd9, 8'd253};
            16'hff9d: e = '{1'b1, 4'd9, 8'd239};
            16'hff9e: e = '{1'b1, 4'd9, 8'd223};
            16'hff1b: e = '{1'b1, 4'd8, 8'd251};
            default:  e = '{1'b0, ROW_W'(0), 8'd255};
        endcase
        return e;
    endfunction

    // commands for function keys, offset from f1
    function automatic logic [3:0] fkey_command(input logic [3:0] idx);
        logic [3:0] c;
        c = CMD_NONE;
        case (idx)
            4'd0:    c = CMD_INFO;
            4'd1:    c = CMD_NONE;
            4'd2:    c = CMD_DISK0;
            4'd3:    c = CMD_DISK1;
            4'd4:    c = CMD_SOUND;
            4'd5:    c = CMD_SCREENSHOT;
            4'd6:    c = CMD_SETUP;
            4'd7:    c = CMD_RESET;
            4'd8:    c = CMD_PRN_CLOSE;
            4'd9:    c = CMD_DEBUG;
            4'd10:   c = CMD_EXIT;
            4'd11:   c = CMD_EXIT;
            default: c = CMD_NONE;
        endcase
        return c;
    endfunction

endpackage

@@ hdl/hkm_decode.sv @@
// key decoder: turns one item into the matrix and flag change it asks for
module hkm_decode
    import hkm_pkg::*;
(
    input  logic [1:0]  action,
    input  logic [15:0] key_code,
    input  logic        host_shift,
    output hkm_update_t upd
);

    logic           is_print;
    logic           is_shift;
    logic           is_ctrl;
    logic           is_fkey;
    logic [6:0]     rom_idx;
    logic [7:0]     fk_off;
    ascii_entry_t   rom;
    special_entry_t sp;

    assign is_print = (key_code >= KEY_PRINT_LO) && (key_code <= KEY_PRINT_HI);
    assign is_shift = (key_code == KEY_SHIFT_L) || (key_code == KEY_SHIFT_R);
    assign is_ctrl  = (key_code == KEY_CTRL_L) || (key_code == KEY_CTRL_R);
    assign is_fkey  = (key_code >= KEY_F1) && (key_code <= KEY_F12);
    assign rom_idx  = key_code[6:0] - KEY_PRINT_LO[6:0];
    assign fk_off   = key_code[7:0] - KEY_F1[7:0];
    assign rom      = ASCII_ROM[rom_idx];
    assign sp       = special_lookup(key_code);

    always_comb begin
        upd          = '0;
        upd.tgt_and  = 8'hff;
        upd.shift_op = SHIFT_OP_NONE;
        upd.cmd      = CMD_NONE;
        case (action)
            ACT_PRESS: begin
                if (is_print) begin
                    upd.tgt_en   = 1'b1;
                    upd.tgt_row  = rom.row;
                    upd.tgt_and  = rom.mask;
                    upd.shift_op = rom.shift ? SHIFT_OP_CLR : SHIFT_OP_SET;
                end else begin
                    // special keys drive the shift bit from the held host shift
                    upd.shift_op = host_shift ? SHIFT_OP_CLR : SHIFT_OP_SET;
                    if (is_shift) begin
                        upd.hsf_set = 1'b1;
                    end else if (is_fkey) begin
                        upd.cmd = fkey_command(fk_off[3:0]);
                    end else if (sp.hit) begin
                        upd.tgt_en   = 1'b1;
                        upd.tgt_row  = sp.row;
                        upd.tgt_and  = sp.mask;
                        upd.ctrl_set = is_ctrl;
                    end
                end
            end
            ACT_RELEASE: begin
                if (is_print) begin
                    upd.tgt_en  = 1'b1;
                    upd.tgt_row = rom.row;
                    upd.tgt_or  = ~rom.mask;
                    if (rom.shift) begin
                        upd.shift_op = SHIFT_OP_SET;
                    end
                end else if (is_shift) begin
                    upd.shift_op = SHIFT_OP_SET;
                    upd.hsf_clr  = 1'b1;
                end else if (sp.hit) begin
                    upd.tgt_en   = 1'b1;
                    upd.tgt_row  = sp.row;
                    upd.tgt_or   = ~sp.mask;
                    upd.ctrl_clr = is_ctrl;
                end
            end
            default: begin
                // read only, nothing changes
            end
        endcase
    end

endmodule

@@ hdl/hkm_matrix.sv @@
// keyboard matrix and host flags, with per-row update lanes and row readout
module hkm_matrix
    import hkm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             upd_en,
    input  hkm_update_t      upd,
    input  logic [SEL_W-1:0] row_select,
    output logic             host_shift,
    output hkm_result_t      result
);

    logic [ROW_BITS-1:0] matrix_reg  [MATRIX_ROWS];
    logic [ROW_BITS-1:0] matrix_next [MATRIX_ROWS];
    logic [ROW_BITS-1:0] lane_val    [MATRIX_ROWS];
    logic                hsf_reg;
    logic                hsf_next;
    logic                ctrl_reg;
    logic                ctrl_next;
    logic                hsf_new;
    logic                ctrl_new;

    // every row has its own lane; target op first, then the shift bit
    always_comb begin
        for (int r = 0; r < MATRIX_ROWS; r++) begin
            lane_val[r] = matrix_reg[r];
            if (upd.tgt_en && (upd.tgt_row == ROW_W'(r))) begin
                lane_val[r] = (lane_val[r] & upd.tgt_and) | upd.tgt_or;
            end
            if (ROW_W'(r) == SHIFT_ROW) begin
                case (upd.shift_op)
                    SHIFT_OP_CLR: lane_val[r] = lane_val[r] & SHIFT_CLR;
                    SHIFT_OP_SET: lane_val[r] = lane_val[r] | SHIFT_SET;
                    default:      lane_val[r] = lane_val[r];
                endcase
            end
            matrix_next[r] = upd_en ? lane_val[r] : matrix_reg[r];
        end
    end

    assign hsf_new   = upd.hsf_set ? 1'b1 : (upd.hsf_clr ? 1'b0 : hsf_reg);
    assign ctrl_new  = upd.ctrl_set ? 1'b1 : (upd.ctrl_clr ? 1'b0 : ctrl_reg);
    assign hsf_next  = upd_en ? hsf_new : hsf_reg;
    assign ctrl_next = upd_en ? ctrl_new : ctrl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < MATRIX_ROWS; r++) begin
                matrix_reg[r] <= ROW_IDLE;
            end
            hsf_reg  <= 1'b0;
            ctrl_reg <= 1'b0;
        end else begin
            matrix_reg <= matrix_next;
            hsf_reg    <= hsf_next;
            ctrl_reg   <= ctrl_next;
        end
    end

    assign host_shift = hsf_reg;

    // result reflects the state after this item
    always_comb begin
        result              = '0;
        result.row_value    = ROW_IDLE;
        if ({1'b0, row_select} < (SEL_W+1)'(MATRIX_ROWS)) begin
            result.row_value = lane_val[row_select[ROW_W-1:0]];
        end
        result.host_command = upd.cmd;
        result.ctrl_held    = ctrl_new;
        result.shift_held   = hsf_new;
    end

endmodule

@@ hdl/host_key_to_matrix_mapper_top.sv @@
// top level of the host key to matrix mapper: item registers, handshake and checks
//
// keeps a ten-row, eight-bit active-low keyboard matrix (all ones after reset)
// together with held host shift and control flags. each input item is a key
// press, a key release or a plain row read (any other action code reads only);
// it carries a host key code (printable 32 to 125 or a 0xffxx key symbol) and
// a row to report. exactly one result item answers every input item, in order:
// the chosen row after the item's change (rows 10 to 15 read as all ones),
// the control and shift flags after the change, and a host command for f1 to
// f12 presses. an item passes through the input register and then the output
// register; a new item is taken every cycle unless both registers hold an item
// and the output is not taken. the matrix read-modify-write happens in the cycle
// that moves an item from the input register to the output register. there are
// no configuration registers and no start-up sweep
module host_key_to_matrix_mapper_top
    import hkm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // key_code [15:0], row_select [19:16], zero [23:20]
    input  logic [1:0]  s_tuser,   // action [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // row_value [7:0], host_command [11:8],
                                   // ctrl_held [12], shift_held [13], zero [15:14]
);

    // input register
    logic             in_valid_reg;
    logic             in_valid_next;
    logic [1:0]       in_action_reg;
    logic [1:0]       in_action_next;
    logic [15:0]      in_key_reg;
    logic [15:0]      in_key_next;
    logic [SEL_W-1:0] in_sel_reg;
    logic [SEL_W-1:0] in_sel_next;

    // output register
    logic             out_valid_reg;
    logic             out_valid_next;
    hkm_result_t      out_res_reg;
    hkm_result_t      out_res_next;

    logic             advance;
    logic             fire;
    logic             host_shift;
    hkm_update_t      upd;
    hkm_result_t      result;

    // the output register frees up when it is empty or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_action_next = in_action_reg;
        in_key_next    = in_key_reg;
        in_sel_next    = in_sel_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_action_next = s_tuser;
            in_key_next    = s_tdata[15:0];
            in_sel_next    = s_tdata[19:16];
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (advance) begin
            out_valid_next = in_valid_reg;
        end
        if (fire) begin
            out_res_next = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        in_action_reg <= in_action_next;
        in_key_reg    <= in_key_next;
        in_sel_reg    <= in_sel_next;
        out_res_reg   <= out_res_next;
    end

    hkm_decode u_decode (
        .action     (in_action_reg),
        .key_code   (in_key_reg),
        .host_shift (host_shift),
        .upd        (upd)
    );

    hkm_matrix u_matrix (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .upd_en     (fire),
        .upd        (upd),
        .row_select (in_sel_reg),
        .host_shift (host_shift),
        .result     (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg.shift_held, out_res_reg.ctrl_held,
                       out_res_reg.host_command, out_res_reg.row_value};

    // a command only ever comes out of a press
    a_cmd_only_on_press: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (fire && (in_action_reg != ACT_PRESS)) |=> (m_tdata[11:8] == CMD_NONE)
    ) else $error("host command on a non-press item");

    // rows beyond the matrix read as all ones
    a_row_beyond: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (fire && ({1'b0, in_sel_reg} >= (SEL_W+1)'(MATRIX_ROWS)))
            |=> (m_tdata[7:0] == ROW_IDLE)
    ) else $error("row beyond the matrix not all ones");

    // backpressure only when both registers hold an item
    a_stall_full: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready)
    ) else $error("input stalled with room in the pipeline");

    // a fired item shows up at the output in the next cycle
    a_fire_to_out: assert property (
        @(posedge aclk) disable iff (!aresetn)
        fire |=> m_tvalid
    ) else $error("fired item lost");

endmodule
